[hdl/rtprs_pkg.sv]
// Shared types and constants for the RTP receive statistics block.
package rtprs_pkg;

    localparam int unsigned SEQ_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned BYTE_W   = 48;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LOST_W   = 31;
    localparam int unsigned JIT_SHIFT = 4;

    localparam logic [CFG_W-1:0] MAX_DROPOUT_RESET  = 16'd3000;
    localparam logic [CFG_W-1:0] MAX_MISORDER_RESET = 16'd100;
    localparam logic signed [SEQ_W+1:0] HALF_SPAN   = 18'sd32768;
    localparam logic signed [SEQ_W+1:0] SEQ_SPAN    = 18'sd65536;

    localparam logic CFG_MAX_DROPOUT  = 1'b0;
    localparam logic CFG_MAX_MISORDER = 1'b1;

    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_FORWARD      = 3'd0,
        ST_REORDERED    = 3'd1,
        ST_FIRST        = 3'd2,
        ST_JUMP_DROPPED = 3'd3,
        ST_OLD_DROPPED  = 3'd4,
        ST_CLEARED      = 3'd5
    } status_t;

endpackage

[hdl/rtp_receive_statistics_top.sv]
// RTP receive statistics: sequence tracking, loss, jitter and counters per packet.
//
// The block accepts one transaction per clock cycle while the result side is not
// stalled and returns exactly one result for each, passing it through the state
// registers and then the result registers. The rate is set by the per-packet state
// update (sequence fold, drop decision and jitter update); the loss figure is
// derived from the updated state in the following result stage. Configuration
// writes are taken at any time and should be made while the block is idle.
module rtp_receive_statistics_top
    import rtprs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [SEQ_W-1:0]    s_seq_number,
    input  logic [TIME_W-1:0]   s_rtp_timestamp,
    input  logic [TIME_W-1:0]   s_arrival_ms,
    input  logic [SEQ_W-1:0]    s_payload_bytes,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [CNT_W-1:0]    m_extended_highest,
    output logic [LOST_W-1:0]   m_cumulative_lost,
    output logic [CNT_W-1:0]    m_jitter_value,
    output logic [CNT_W-1:0]    m_received_packets,
    output logic [BYTE_W-1:0]   m_received_bytes,
    output logic [CNT_W-1:0]    m_reordered_packets
);

    logic [CFG_W-1:0]  max_dropout_reg, max_misorder_reg;

    logic              started_reg, started_next;
    logic [SEQ_W-1:0]  highest_reg, highest_next;
    logic [SEQ_W-1:0]  wrap_hi_reg, wrap_hi_next;
    logic [SEQ_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]  pkt_count_reg, pkt_count_next;
    logic [BYTE_W-1:0] byte_count_reg, byte_count_next;
    logic [CNT_W-1:0]  reorder_reg, reorder_next;
    logic [CNT_W-1:0]  jitter_reg, jitter_next;
    logic [TIME_W-1:0] prev_transit_reg, prev_transit_next;
    status_t           status_reg, status_next;
    logic              a_valid_reg, a_valid_next;

    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg;
    logic [CNT_W-1:0]  m_ext_reg;
    logic [LOST_W-1:0] m_lost_reg;
    logic [CNT_W-1:0]  m_jitter_reg;
    logic [CNT_W-1:0]  m_packets_reg;
    logic [BYTE_W-1:0] m_bytes_reg;
    logic [CNT_W-1:0]  m_reorder_reg;

    logic b_load, in_accept;

    logic signed [SEQ_W+1:0] raw_delta, delta;
    logic                    drop_jump, drop_old;
    logic [TIME_W-1:0]       transit, raw, mag;
    logic signed [TIME_W+1:0] jit_diff, jit_adj, jit_q;
    logic [CNT_W-1:0]        jitter_upd;

    logic [CNT_W-1:0]  ext_cur, expected, lost_diff;
    logic [LOST_W-1:0] lost_val;

    // Handshake: the state stage holds the result of the last accepted transaction.
    assign b_load    = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || b_load;
    assign in_accept = s_valid && s_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (in_accept) begin
            a_valid_next = 1'b1;
        end else if (b_load) begin
            a_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (b_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Sequence distance folded into -32768..32768 and the two drop decisions.
    always_comb begin
        raw_delta = $signed({2'b00, s_seq_number}) - $signed({2'b00, highest_reg});
        if (raw_delta > HALF_SPAN) begin
            delta = raw_delta - SEQ_SPAN;
        end else if (raw_delta < -HALF_SPAN) begin
            delta = raw_delta + SEQ_SPAN;
        end else begin
            delta = raw_delta;
        end
        drop_jump = !delta[SEQ_W+1] && (delta > $signed({2'b00, max_dropout_reg}));
        drop_old  = delta[SEQ_W+1] && (delta < -$signed({2'b00, max_misorder_reg}));
    end

    // Jitter update with the quotient truncated toward zero.
    always_comb begin
        transit    = s_arrival_ms - s_rtp_timestamp;
        raw        = transit - prev_transit_reg;
        mag        = raw[TIME_W-1] ? (TIME_W'(0) - raw) : raw;
        jit_diff   = $signed({2'b00, mag}) - $signed({2'b00, jitter_reg});
        jit_adj    = jit_diff[TIME_W+1] ? (jit_diff + 34'sd15) : jit_diff;
        jit_q      = jit_adj >>> JIT_SHIFT;
        jitter_upd = jitter_reg + jit_q[CNT_W-1:0];
    end

    always_comb begin
        started_next      = started_reg;
        highest_next      = highest_reg;
        wrap_hi_next      = wrap_hi_reg;
        first_next        = first_reg;
        pkt_count_next    = pkt_count_reg;
        byte_count_next   = byte_count_reg;
        reorder_next      = reorder_reg;
        jitter_next       = jitter_reg;
        prev_transit_next = prev_transit_reg;
        status_next       = status_reg;
        if (in_accept) begin
            if (s_req_type == REQ_CLEAR) begin
                started_next    = 1'b0;
                pkt_count_next  = '0;
                byte_count_next = '0;
                reorder_next    = '0;
                jitter_next     = '0;
                status_next     = ST_CLEARED;
            end else if (!started_reg) begin
                started_next      = 1'b1;
                first_next        = s_seq_number;
                highest_next      = s_seq_number;
                wrap_hi_next      = '0;
                pkt_count_next    = CNT_W'(1);
                byte_count_next   = BYTE_W'(s_payload_bytes);
                prev_transit_next = transit;
                status_next       = ST_FIRST;
            end else if (drop_jump) begin
                status_next = ST_JUMP_DROPPED;
            end else if (drop_old) begin
                status_next = ST_OLD_DROPPED;
            end else begin
                if (!delta[SEQ_W+1]) begin
                    if (s_seq_number < highest_reg) begin
                        wrap_hi_next = wrap_hi_reg + SEQ_W'(1);
                    end
                    highest_next = s_seq_number;
                    status_next  = ST_FORWARD;
                end else begin
                    reorder_next = reorder_reg + CNT_W'(1);
                    status_next  = ST_REORDERED;
                end
                jitter_next       = jitter_upd;
                prev_transit_next = transit;
                pkt_count_next    = pkt_count_reg + CNT_W'(1);
                byte_count_next   = byte_count_reg + BYTE_W'(s_payload_bytes);
            end
        end
    end

    // Result stage: loss is expected minus received, clamped at zero.
    always_comb begin
        ext_cur   = {wrap_hi_reg, highest_reg};
        expected  = ext_cur - CNT_W'(first_reg) + CNT_W'(1);
        lost_diff = expected - pkt_count_reg;
        lost_val  = (started_reg && !lost_diff[CNT_W-1]) ? lost_diff[LOST_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dropout_reg  <= MAX_DROPOUT_RESET;
            max_misorder_reg <= MAX_MISORDER_RESET;
            started_reg      <= 1'b0;
            highest_reg      <= '0;
            wrap_hi_reg      <= '0;
            first_reg        <= '0;
            pkt_count_reg    <= '0;
            byte_count_reg   <= '0;
            reorder_reg      <= '0;
            jitter_reg       <= '0;
            prev_transit_reg <= '0;
            status_reg       <= ST_FORWARD;
            a_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MAX_DROPOUT:  max_dropout_reg  <= cfg_wr_data;
                    CFG_MAX_MISORDER: max_misorder_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            started_reg      <= started_next;
            highest_reg      <= highest_next;
            wrap_hi_reg      <= wrap_hi_next;
            first_reg        <= first_next;
            pkt_count_reg    <= pkt_count_next;
            byte_count_reg   <= byte_count_next;
            reorder_reg      <= reorder_next;
            jitter_reg       <= jitter_next;
            prev_transit_reg <= prev_transit_next;
            status_reg       <= status_next;
            a_valid_reg      <= a_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            m_status_reg  <= status_reg;
            m_ext_reg     <= ext_cur;
            m_lost_reg    <= lost_val;
            m_jitter_reg  <= jitter_reg;
            m_packets_reg <= pkt_count_reg;
            m_bytes_reg   <= byte_count_reg;
            m_reorder_reg <= reorder_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_extended_highest  = m_ext_reg;
    assign m_cumulative_lost   = m_lost_reg;
    assign m_jitter_value      = m_jitter_reg;
    assign m_received_packets  = m_packets_reg;
    assign m_received_bytes    = m_bytes_reg;
    assign m_reordered_packets = m_reorder_reg;

    // A cleared result shows empty counters, no loss and no jitter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_CLEARED) |->
        (m_received_packets == '0 && m_cumulative_lost == '0 && m_jitter_value == '0))
        else $error("cleared result carries stale statistics");

    // The first packet starts the count at one with no loss.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FIRST) |->
        (m_received_packets == 32'd1 && m_cumulative_lost == '0))
        else $error("first packet result is inconsistent");

    // A dropped packet leaves the receive state untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && (status_reg == ST_JUMP_DROPPED || status_reg == ST_OLD_DROPPED)) |->
        (pkt_count_reg == $past(pkt_count_reg) && highest_reg == $past(highest_reg) &&
         jitter_reg == $past(jitter_reg)))
        else $error("dropped packet changed the receive state");

    // Input is held off only while both stages are occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (a_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

endmodule
